// ===== design/mre_pkg.sv =====
// Shared types, codes and helpers for the meter record encoder.
// Used by the front, queue, back and top-level modules.
package mre_pkg;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_LEN = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic       OP_APPEND = 1'b0;
    localparam logic       OP_CLEAR  = 1'b1;

    localparam logic [7:0] BCD_FLAG  = 8'h08;
    localparam logic [7:0] LEN_MASK  = 8'h07;
    localparam logic [7:0] BYTE_MASK = 8'hFF;

    localparam logic [31:0] RECIP_100 = 32'h51EB851F;
    localparam int          RECIP_SHIFT = 37;

    localparam logic [7:0] CAPACITY_RESET = 8'd255;
    localparam logic       REG_CAPACITY = 1'b0;

    typedef struct packed {
        logic        single;
        logic [1:0]  status;
        logic [7:0]  dif;
        logic [31:0] vif;
        logic [2:0]  vlen;
        logic [31:0] value;
        logic [7:0]  pos;
        logic [7:0]  size;
    } t_cmd;

    // Two BCD digits of a value below 100, tens in the high nibble.
    function automatic logic [7:0] bin_to_bcd(input logic [6:0] r);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  units;
        prod  = {8'd0, r} * 15'd205;
        tens  = prod[14:11];
        units = r - ({3'd0, tens} * 7'd10);
        return {tens, units[3:0]};
    endfunction

endpackage

// ===== design/mre_front.sv =====
// Front end: accepts items, classifies them and tracks the write position.
// Depends on mre_pkg; pushes one command per item into mre_queue.
module mre_front
    import mre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_dif,
    input  logic [31:0] i_vif,
    input  logic [31:0] i_value,
    input  logic [7:0]  i_capacity,
    input  logic        i_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic [7:0] r_write_pos;
    logic [7:0] n_write_pos;
    logic [2:0] w_len;
    logic [2:0] w_vlen;
    logic [3:0] w_total;
    logic [8:0] w_sum;
    logic       w_bad_len;
    logic       w_overflow;
    logic [31:0] w_vif_aligned;

    assign o_in_stall = i_full;
    assign o_push     = i_in_valid && !i_full;

    assign w_len     = 3'(i_dif & LEN_MASK);
    assign w_bad_len = (w_len == 3'd0) || (w_len > 3'd4);

    always_comb begin
        if (i_vif[31:24] != 8'd0) begin
            w_vlen = 3'd4;
        end else if (i_vif[23:16] != 8'd0) begin
            w_vlen = 3'd3;
        end else if (i_vif[15:8] != 8'd0) begin
            w_vlen = 3'd2;
        end else if (i_vif[7:0] != 8'd0) begin
            w_vlen = 3'd1;
        end else begin
            w_vlen = 3'd0;
        end
    end

    // Left-justify the VIF so the back end always emits the top byte.
    always_comb begin
        case (w_vlen)
            3'd1:    w_vif_aligned = {i_vif[7:0], 24'd0};
            3'd2:    w_vif_aligned = {i_vif[15:0], 16'd0};
            3'd3:    w_vif_aligned = {i_vif[23:0], 8'd0};
            default: w_vif_aligned = i_vif;
        endcase
    end

    assign w_total    = 4'd1 + {1'b0, w_vlen} + {1'b0, w_len};
    assign w_sum      = {1'b0, r_write_pos} + {5'd0, w_total};
    assign w_overflow = w_sum > {1'b0, i_capacity};

    always_comb begin
        o_cmd.dif   = i_dif;
        o_cmd.vif   = w_vif_aligned;
        o_cmd.vlen  = w_vlen;
        o_cmd.value = i_value;
        o_cmd.pos   = r_write_pos;
        o_cmd.size  = w_sum[7:0];
        n_write_pos = r_write_pos;
        if (i_operation == OP_CLEAR) begin
            o_cmd.single = 1'b1;
            o_cmd.status = STATUS_OK;
            n_write_pos  = 8'd0;
        end else if (w_bad_len) begin
            o_cmd.single = 1'b1;
            o_cmd.status = STATUS_BAD_LEN;
        end else if (w_overflow) begin
            o_cmd.single = 1'b1;
            o_cmd.status = STATUS_OVERFLOW;
        end else begin
            o_cmd.single = 1'b0;
            o_cmd.status = STATUS_OK;
            n_write_pos  = w_sum[7:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_pos <= 8'd0;
        end else if (o_push) begin
            r_write_pos <= n_write_pos;
        end
    end

endmodule

// ===== design/mre_queue.sv =====
// Short command queue between the front and back ends.
// Depends on mre_pkg for the command type and depth.
module mre_queue
    import mre_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== design/mre_back.sv =====
// Back end: walks one queued command and emits its record bytes.
// Depends on mre_pkg; BCD bytes use a reciprocal multiply by 1/100.
module mre_back
    import mre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_cmd        i_q_cmd,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic [7:0]  o_byte_pos,
    output logic [1:0]  o_status,
    output logic [7:0]  o_size_after,
    output logic        o_last
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIF  = 3'd1;
    localparam logic [2:0] S_VIF  = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_DATA = 3'd4;
    localparam logic [2:0] S_ONE  = 3'd5;

    logic [2:0]  r_state;
    logic [2:0]  n_state;
    logic [7:0]  r_dif;
    logic [31:0] r_vif;
    logic [2:0]  r_vcnt;
    logic [31:0] r_val;
    logic [26:0] r_quot;
    logic [2:0]  r_dcnt;
    logic [7:0]  r_pos;
    logic [7:0]  r_size;
    logic [1:0]  r_status;
    logic        r_bcd;

    logic        w_out_free;
    logic        w_emit;
    logic [7:0]  w_byte;
    logic        w_last;
    logic [63:0] w_prod;
    logic [33:0] w_q100;
    logic [31:0] w_rem;

    assign w_out_free = !o_out_valid || !i_out_stall;
    assign o_pop      = (r_state == S_IDLE) && !i_q_empty;

    assign w_prod = r_val * RECIP_100;
    assign w_q100 = {1'b0, r_quot, 6'd0} + {2'b0, r_quot, 5'd0} + {5'd0, r_quot, 2'd0};
    assign w_rem  = r_val - w_q100[31:0];

    always_comb begin
        w_emit  = 1'b0;
        w_byte  = 8'd0;
        w_last  = 1'b0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_q_cmd.single ? S_ONE : S_DIF;
                end
            end
            S_DIF: begin
                w_emit = w_out_free;
                w_byte = r_dif;
                if (w_out_free) begin
                    n_state = (r_vcnt != 3'd0) ? S_VIF : S_PREP;
                end
            end
            S_VIF: begin
                w_emit = w_out_free;
                w_byte = r_vif[31:24];
                if (w_out_free && r_vcnt == 3'd1) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = S_DATA;
            end
            S_DATA: begin
                w_emit = w_out_free;
                w_byte = r_bcd ? bin_to_bcd(w_rem[6:0]) : r_val[7:0];
                w_last = (r_dcnt == 3'd1);
                if (w_out_free) begin
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else if (r_bcd) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_ONE: begin
                w_emit = w_out_free;
                w_last = 1'b1;
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_emit) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // Command payload and byte counters.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_dif    <= i_q_cmd.dif;
            r_vif    <= i_q_cmd.vif;
            r_vcnt   <= i_q_cmd.vlen;
            r_val    <= i_q_cmd.value;
            r_dcnt   <= 3'(i_q_cmd.dif & LEN_MASK);
            r_bcd    <= (i_q_cmd.dif & BCD_FLAG) != 8'd0;
            r_pos    <= i_q_cmd.pos;
            r_size   <= i_q_cmd.size;
            r_status <= i_q_cmd.status;
        end else begin
            if (r_state == S_PREP) begin
                r_quot <= w_prod[63:RECIP_SHIFT];
            end
            if (w_emit) begin
                r_pos <= r_pos + 8'd1;
            end
            if (w_emit && r_state == S_VIF) begin
                r_vif  <= {r_vif[23:0], 8'd0};
                r_vcnt <= r_vcnt - 3'd1;
            end
            if (w_emit && r_state == S_DATA) begin
                r_val  <= r_bcd ? {5'd0, r_quot} : {8'd0, r_val[31:8]};
                r_dcnt <= r_dcnt - 3'd1;
            end
        end
    end

    // Output register; hold while stalled.
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            o_out_byte <= w_byte;
            o_last     <= w_last;
            if (r_state == S_ONE) begin
                o_byte_pos   <= 8'd0;
                o_status     <= r_status;
                o_size_after <= 8'd0;
            end else begin
                o_byte_pos   <= r_pos;
                o_status     <= STATUS_OK;
                o_size_after <= r_size;
            end
        end
    end

endmodule

// ===== design/meter_record_encoder.sv =====
// Top level of the meter record encoder: config port, front, queue, back.
// Depends on mre_pkg, mre_front, mre_queue and mre_back.
//
//   channel   direction  handshake                 payload
//   in        input      i_in_valid / o_in_stall   i_operation i_dif i_vif i_value
//   out       output     o_out_valid / i_out_stall o_out_byte o_byte_pos o_status
//                                                  o_size_after o_last
//   config    APB        psel penable pwrite       paddr pwdata prdata pready
//
// A binary append item is popped in idle, emits its DIF byte and VIF bytes, passes a
// prepare state and emits its data bytes; a BCD append item passes the prepare state
// before each data byte, waiting for the divide-by-100 multiply; clear and error items
// emit a single byte. The sequencer emits one byte per cycle at most, unless stalled.
// Reset clears the write position, the queue and the output valid; capacity goes to 255.
// The two-entry queue lets the front accept items while the output is stalled.
module meter_record_encoder
    import mre_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_operation,
    input  logic [7:0]  i_dif,
    input  logic [31:0] i_vif,
    input  logic [31:0] i_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic [7:0]  o_byte_pos,
    output logic [1:0]  o_status,
    output logic [7:0]  o_size_after,
    output logic        o_last
);

    logic [7:0] r_capacity;
    logic       w_push;
    logic       w_full;
    logic       w_pop;
    logic       w_empty;
    t_cmd       w_push_cmd;
    t_cmd       w_head_cmd;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {24'd0, r_capacity} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
            r_capacity <= pwdata[7:0];
        end
    end

    mre_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_operation(i_operation),
        .i_dif      (i_dif),
        .i_vif      (i_vif),
        .i_value    (i_value),
        .i_capacity (r_capacity),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    mre_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_cmd  (w_push_cmd),
        .o_full (w_full),
        .i_pop  (w_pop),
        .o_empty(w_empty),
        .o_cmd  (w_head_cmd)
    );

    mre_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (w_empty),
        .i_q_cmd     (w_head_cmd),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_byte  (o_out_byte),
        .o_byte_pos  (o_byte_pos),
        .o_status    (o_status),
        .o_size_after(o_size_after),
        .o_last      (o_last)
    );

endmodule

// ===== dv/meter_record_encoder_tb.sv =====
// Self-checking testbench for meter_record_encoder: random and directed items,
// with the expected record bytes predicted inside the bench and checked in order.
// Depends on mre_pkg and the meter_record_encoder RTL only.
`timescale 1ns / 1ps

module meter_record_encoder_tb;
    import mre_pkg::*;

    localparam logic [2:0] CAPACITY_ADDR = 3'(4 * REG_CAPACITY);
    localparam int LONG_HOLD = 200;

    typedef struct packed {
        logic        op;
        logic [7:0]  dif;
        logic [31:0] vif;
        logic [31:0] value;
    } meter_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic [7:0] pos;
        logic [1:0] status;
        logic [7:0] size;
        logic       last;
    } rec_byte_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_operation = OP_APPEND;
    logic [7:0]  i_dif = '0;
    logic [31:0] i_vif = '0;
    logic [31:0] i_value = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_out_byte;
    logic [7:0]  o_byte_pos;
    logic [1:0]  o_status;
    logic [7:0]  o_size_after;
    logic        o_last;

    meter_record_encoder dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_operation  (i_operation),
        .i_dif        (i_dif),
        .i_vif        (i_vif),
        .i_value      (i_value),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_byte   (o_out_byte),
        .o_byte_pos   (o_byte_pos),
        .o_status     (o_status),
        .o_size_after (o_size_after),
        .o_last       (o_last)
    );

    always #1 i_clk = ~i_clk;

    meter_item_t pending_items[$];
    rec_byte_t   expected_bytes[$];
    logic [7:0]  payload_size = 8'd0;
    logic [7:0]  capacity_limit = CAPACITY_RESET;
    bit          idle_on = 1'b1;
    bit          item_taken = 1'b0;
    int          queued_count = 0;
    int          accepted_count = 0;
    int          send_gap = 0;
    int          stall_left = 0;
    int          long_hold_left = 0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          mismatches = 0;
    int          records_ok = 0;
    int          clears = 0;
    int          bad_lengths = 0;
    int          overflows = 0;
    int          bytes_checked = 0;

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void push_single(input logic [1:0] status);
        rec_byte_t rb;
        rb = '{8'd0, 8'd0, status, 8'd0, 1'b1};
        expected_bytes.push_back(rb);
    endfunction

    // Work out the bytes one item writes into the payload and advance its size.
    function automatic void encode_record(input meter_item_t it);
        logic [7:0]  dlen;
        logic [31:0] v;
        logic [7:0]  seq[$];
        rec_byte_t   rb;
        int          vbytes;
        int          total;
        vbytes = 0;
        dlen = it.dif & LEN_MASK;
        if (it.op == OP_CLEAR) begin
            payload_size = 8'd0;
            clears++;
            push_single(STATUS_OK);
            return;
        end
        if (dlen < 1 || dlen > 4) begin
            bad_lengths++;
            push_single(STATUS_BAD_LEN);
            return;
        end
        v = it.vif;
        while (v != 0) begin
            vbytes++;
            v = v >> 8;
        end
        total = 1 + vbytes + int'(dlen);
        if (int'(payload_size) + total > int'(capacity_limit)) begin
            overflows++;
            push_single(STATUS_OVERFLOW);
            return;
        end
        seq.push_back(it.dif);
        for (int i = vbytes - 1; i >= 0; i--)
            seq.push_back(it.vif[8*i +: 8]);
        v = it.value;
        for (int i = 0; i < int'(dlen); i++) begin
            if ((it.dif & BCD_FLAG) != 0) begin
                // low digit pair first; digits that do not fit are dropped
                seq.push_back({4'((v / 10) % 10), 4'(v % 10)});
                v = v / 100;
            end else begin
                seq.push_back(v[7:0]);
                v = v >> 8;
            end
        end
        foreach (seq[k]) begin
            rb.data   = seq[k];
            rb.pos    = payload_size + 8'(k);
            rb.status = STATUS_OK;
            rb.size   = 8'(int'(payload_size) + total);
            rb.last   = (k == seq.size() - 1);
            expected_bytes.push_back(rb);
        end
        payload_size = 8'(int'(payload_size) + total);
        records_ok++;
    endfunction

    // Mostly well-formed appends with random content; some clears and bad lengths.
    function automatic meter_item_t random_item();
        meter_item_t it;
        int          vbytes;
        it.op = ($urandom_range(0, 31) == 0) ? OP_CLEAR : OP_APPEND;
        it.dif = 8'($urandom);
        if ($urandom_range(0, 9) != 0)
            it.dif[2:0] = 3'($urandom_range(1, 4));
        vbytes = $urandom_range(0, 4);
        it.vif = $urandom;
        if (vbytes < 4)
            it.vif = it.vif & ((32'd1 << (8 * vbytes)) - 32'd1);
        if (vbytes > 0 && it.vif[8*(vbytes-1) +: 8] == 8'd0)
            it.vif[8*(vbytes-1)] = 1'b1;
        case ($urandom_range(0, 3))
            0: it.value = $urandom;
            1: it.value = $urandom_range(0, 99999999);
            2: it.value = $urandom_range(0, 255);
            default: it.value = 32'hFFFF_FFFF;
        endcase
        return it;
    endfunction

    task automatic queue_item(input logic op, input logic [7:0] dif, input logic [31:0] vif,
                              input logic [31:0] value);
        meter_item_t it;
        it = '{op, dif, vif, value};
        pending_items.push_back(it);
        queued_count++;
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || expected_bytes.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        penable <= 1'b0;
        paddr   <= addr;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Change capacity only once the encoder has gone quiet.
    task automatic set_capacity(input logic [7:0] cap);
        logic [31:0] rd;
        wait_drained();
        apb_write(CAPACITY_ADDR, {24'($urandom), cap});
        capacity_limit = cap;
        apb_read(CAPACITY_ADDR, rd);
        check_field("capacity readback", 32'(cap), 32'(rd[7:0]));
    endtask

    task automatic run_phase(input logic [7:0] cap, input int count, input bit with_idle,
                             input bit with_hold);
        meter_item_t it;
        set_capacity(cap);
        idle_on = with_idle;
        for (int n = 0; n < count; n++) begin
            it = random_item();
            queue_item(it.op, it.dif, it.vif, it.value);
        end
        if (with_hold)
            hold_requests++;
    endtask

    // Driver: present pending items, hold each until it is taken.
    always @(negedge i_clk) begin
        meter_item_t next_item;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !item_taken) begin
            // hold the stalled item
        end else if (send_gap > 0) begin
            send_gap--;
            i_in_valid <= 1'b0;
        end else if (pending_items.size() == 0) begin
            i_in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 17);
            i_in_valid <= 1'b0;
        end else begin
            next_item = pending_items.pop_front();
            i_in_valid  <= 1'b1;
            i_operation <= next_item.op;
            i_dif       <= next_item.dif;
            i_vif       <= next_item.vif;
            i_value     <= next_item.value;
        end
    end

    // Receiver: random stall bursts, plus a long hold-off on request.
    always @(negedge i_clk) begin
        if (long_hold_left > 0) begin
            long_hold_left--;
            i_out_stall <= 1'b1;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            long_hold_left = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 17);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: predict on each accepted item, check each accepted output byte.
    always @(posedge i_clk) begin
        rec_byte_t want;
        if (!i_rst_n) begin
            item_taken = 1'b0;
        end else begin
            item_taken = i_in_valid && !o_in_stall;
            if (item_taken) begin
                encode_record('{i_operation, i_dif, i_vif, i_value});
                accepted_count++;
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    $display("%0t: unexpected output, expected none, actual byte %0h pos %0h",
                             $time, o_out_byte, o_byte_pos);
                    mismatches++;
                end else begin
                    want = expected_bytes.pop_front();
                    check_field("out_byte", 32'(want.data), 32'(o_out_byte));
                    check_field("byte_pos", 32'(want.pos), 32'(o_byte_pos));
                    check_field("status", 32'(want.status), 32'(o_status));
                    check_field("size_after", 32'(want.size), 32'(o_size_after));
                    check_field("last", 32'(want.last), 32'(o_last));
                    bytes_checked++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        logic [31:0] rd;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        apb_read(CAPACITY_ADDR, rd);
        check_field("capacity after reset", 32'(CAPACITY_RESET), 32'(rd[7:0]));

        // directed: field extremes, binary and BCD coding, bad lengths
        queue_item(OP_CLEAR,  8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(OP_APPEND, 8'h01, 32'h0000_0000, 32'h0000_0000);
        queue_item(OP_APPEND, 8'h04, 32'h0000_00FD, 32'hFFFF_FFFF);
        queue_item(OP_APPEND, 8'h02, 32'hFFFF_FFFF, 32'h1234_5678);
        queue_item(OP_APPEND, 8'h03, 32'h0001_0000, 32'h00AB_CDEF);
        queue_item(OP_APPEND, 8'h09, 32'h0000_0013, 32'd7);
        queue_item(OP_APPEND, 8'h0C, 32'h0000_0000, 32'd99999999);
        queue_item(OP_APPEND, 8'h0A, 32'h0000_FB00, 32'd1234);
        queue_item(OP_APPEND, 8'h0B, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_item(OP_APPEND, 8'h09, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_item(OP_APPEND, 8'hF4, 32'h8000_0000, 32'h8000_0001);
        queue_item(OP_APPEND, 8'hFC, 32'h0000_0080, 32'h0000_0000);
        queue_item(OP_APPEND, 8'h00, 32'h0000_0012, 32'd5);
        queue_item(OP_APPEND, 8'h05, 32'h0000_0000, 32'd5);
        queue_item(OP_APPEND, 8'h0E, 32'h0000_0000, 32'd5);
        queue_item(OP_APPEND, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_item(OP_CLEAR,  8'h00, 32'h0000_0000, 32'h0000_0000);

        // capacity edge: fill exactly, overflow, length check first
        set_capacity(8'd11);
        queue_item(OP_APPEND, 8'h04, 32'h0102_0304, 32'hCAFE_F00D);
        queue_item(OP_APPEND, 8'h01, 32'h0000_0005, 32'd1);
        queue_item(OP_APPEND, 8'h01, 32'h0000_0000, 32'd2);
        queue_item(OP_APPEND, 8'h07, 32'h0000_0000, 32'd3);
        queue_item(OP_APPEND, 8'h01, 32'h0000_0000, 32'd4);
        queue_item(OP_CLEAR,  8'h01, 32'h0000_0000, 32'd0);

        set_capacity(8'd0);
        queue_item(OP_APPEND, 8'h01, 32'h0000_0000, 32'd9);
        queue_item(OP_CLEAR,  8'h00, 32'h0000_0000, 32'd0);

        // random phases; first one carries the long output hold-off
        run_phase(8'd255, 120, 1'b1, 1'b1);
        run_phase(8'($urandom_range(10, 60)), 80, 1'b1, 1'b0);
        run_phase(8'd255, 100, 1'b0, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 80, 1'b1, 1'b0);
        run_phase(8'd9, 30, 1'b1, 1'b0);
        run_phase(8'd255, 70, 1'b0, 1'b0);

        wait_drained();
        repeat (40) @(negedge i_clk);
        $display("Covered %0d items: %0d records, %0d clears, %0d bad lengths, %0d overflows",
                 accepted_count, records_ok, clears, bad_lengths, overflows);
        $display("Checked %0d output bytes over capacities 0, 9, 11, 255 and random values",
                 bytes_checked);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/mre_pkg.sv
design/mre_front.sv
design/mre_queue.sv
design/mre_back.sv
design/meter_record_encoder.sv
dv/meter_record_encoder_tb.sv
